// ===== rtl/cdq_pkg.sv =====
package cdq_pkg;

  // request codes
  typedef logic [2:0] req_t;
  localparam req_t REQ_PUSH_FRONT = 3'd0;
  localparam req_t REQ_PUSH_BACK  = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_CLEAR      = 3'd4;
  localparam req_t REQ_SEARCH     = 3'd5;

  // result status codes
  typedef logic [1:0] stat_t;
  localparam stat_t ST_OK    = 2'd0;
  localparam stat_t ST_FULL  = 2'd1;
  localparam stat_t ST_EMPTY = 2'd2;
  localparam stat_t ST_MISS  = 2'd3;

  typedef logic [2:0]  kind_t;
  typedef logic [15:0] amount_t;
  typedef logic [7:0]  speed_t;

  // one stored command
  typedef struct packed {
    kind_t   kind;
    logic    sign;
    amount_t amount;
    speed_t  speed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/cdq_ram.sv =====
module cdq_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/command_deque_with_search_top.sv =====
// bounded double-ended queue of motion commands with a first-match search
//
// request channel (req_valid / req_ready): one beat carries req_type and the
// command fields; push front, push back, pop front, pop back, clear, search.
// response channel (rsp_valid / rsp_ready): exactly one beat per request,
// with status, the popped or found entry (zero otherwise), entry_total and
// is_empty as they stand after the request.
//
// entries live in a single-port-write, registered-read ram; front pointer and
// count live in flops. push, clear and unused codes go through exec and done,
// as do pops on an empty queue; other pops add a read state for the ram read,
// and a search on a non-empty queue scans: it reads one entry per cycle from
// the front through the ram read port and checks the kind in the cycle after
// the read, stopping at the first match or after the last entry.
//
// the result sits in an output register, so the next request is taken while
// an earlier response waits; if the receiver stalls, the following request
// finishes its work and then holds until the output register frees up.
// reset empties the queue and zeroes the front pointer; ram contents are
// left as they are, since only entries inside the occupied range are read.
module command_deque_with_search_top #(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  cdq_pkg::req_t         req_type,
  input  cdq_pkg::kind_t        cmd_kind,
  input  logic                  cmd_sign,
  input  cdq_pkg::amount_t      cmd_amount,
  input  cdq_pkg::speed_t       cmd_speed,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output cdq_pkg::stat_t        status,
  output cdq_pkg::kind_t        out_kind,
  output logic                  out_sign,
  output cdq_pkg::amount_t      out_amount,
  output cdq_pkg::speed_t       out_speed,
  output logic [CNT_W-1:0]      entry_total,
  output logic                  is_empty
);

  import cdq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_READ = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t             state, state_next;
  req_t               req_q;
  entry_t             ent_q;
  logic [PTR_W-1:0]   front, front_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   scan_idx, scan_next;
  logic               pend, pend_next;
  stat_t              res_status, res_next;
  entry_t             hit, hit_next;

  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [PTR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_ent;

  logic               req_acc;
  logic               load_out;
  logic               full;
  logic               empty;
  logic [PTR_W-1:0]   front_dec;
  logic [PTR_W-1:0]   front_inc;

  // ring index of front + off, off never above DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  cdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ent_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent    = entry_t'(ram_rdata);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? PTR_W'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == PTR_W'(DEPTH - 1)) ? '0 : front + 1'b1;

  // output register is free when empty or being drained this cycle
  assign load_out  = (state == S_DONE) && (!rsp_valid || rsp_ready);
  assign req_ready = (state == S_IDLE) || load_out;
  assign req_acc   = req_valid && req_ready;

  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    scan_next  = scan_idx;
    pend_next  = 1'b0;
    res_next   = res_status;
    hit_next   = hit;
    ram_we     = 1'b0;
    ram_waddr  = front;
    ram_raddr  = front;

    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_next   = ST_OK;
        hit_next   = '0;
        scan_next  = '0;
        state_next = S_DONE;
        unique case (req_q)
          REQ_PUSH_FRONT: begin
            if (full) begin
              res_next = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = front_dec;
              front_next = front_dec;
              count_next = count + 1'b1;
            end
          end
          REQ_PUSH_BACK: begin
            if (full) begin
              res_next = ST_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = wrap_add(front, count);
              count_next = count + 1'b1;
            end
          end
          REQ_POP_FRONT: begin
            if (empty) begin
              res_next = ST_EMPTY;
            end else begin
              ram_raddr  = front;
              front_next = front_inc;
              count_next = count - 1'b1;
              state_next = S_READ;
            end
          end
          REQ_POP_BACK: begin
            if (empty) begin
              res_next = ST_EMPTY;
            end else begin
              ram_raddr  = wrap_add(front, count - 1'b1);
              count_next = count - 1'b1;
              state_next = S_READ;
            end
          end
          REQ_CLEAR: begin
            count_next = '0;
          end
          REQ_SEARCH: begin
            if (empty) begin
              res_next = ST_EMPTY;
            end else begin
              state_next = S_SCAN;
            end
          end
          default: begin
            // unused codes leave the queue alone
          end
        endcase
      end

      S_READ: begin
        hit_next   = rd_ent;
        state_next = S_DONE;
      end

      // one read issued per cycle, the previous one checked
      S_SCAN: begin
        priority if (pend && (rd_ent.kind == ent_q.kind)) begin
          hit_next   = rd_ent;
          res_next   = ST_OK;
          state_next = S_DONE;
        end else if (scan_idx == count) begin
          res_next   = ST_MISS;
          state_next = S_DONE;
        end else begin
          ram_raddr = wrap_add(front, scan_idx);
          scan_next = scan_idx + 1'b1;
          pend_next = 1'b1;
        end
      end

      S_DONE: begin
        if (load_out) begin
          state_next = req_acc ? S_EXEC : S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      pend  <= pend_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx   <= scan_next;
    res_status <= res_next;
    hit        <= hit_next;
    if (req_acc) begin
      req_q         <= req_type;
      ent_q.kind    <= cmd_kind;
      ent_q.sign    <= cmd_sign;
      ent_q.amount  <= cmd_amount;
      ent_q.speed   <= cmd_speed;
    end
    if (load_out) begin
      status      <= res_status;
      out_kind    <= hit.kind;
      out_sign    <= hit.sign;
      out_amount  <= hit.amount;
      out_speed   <= hit.speed;
      entry_total <= count;
      is_empty    <= (count == '0);
    end
  end

  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // a store only happens with room left
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (count < CNT_W'(DEPTH)))
    else $error("ram write into a full queue");

  // the count moves by one per request, or drops to zero on clear
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      ((count == '0) ||
       ((CNT_W+1)'(count) == (CNT_W+1)'($past(count)) + 1'b1) ||
       ((CNT_W+1)'(count) + 1'b1 == (CNT_W+1)'($past(count)))))
    else $error("entry count jumped");

  // a successful search returns an entry of the requested kind
  a_search_kind: assert property (@(posedge clk) disable iff (rst)
    (load_out && (req_q == REQ_SEARCH) && (res_status == ST_OK)) |=>
      (out_kind == $past(ent_q.kind)))
    else $error("search hit with wrong kind");

endmodule
